// ----- rtl/core/acs_pkg.sv -----
// Shared types and constants of the analog control smoother.
// Channel codes, register indexes, the input item, the average memory write beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  // Fraction format of every normalized sample and average
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AlphaBits = 9;
  localparam int unsigned AlphaOne  = 256;
  localparam int unsigned NumCh     = 5;
  localparam int unsigned ChBits    = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 15;

  // Average reset values: 0.85 of full scale, one half, zero
  localparam logic [FracBits-1:0] VolumeInit = 16'((85 * 65535 + 50) / 100);
  localparam logic [FracBits-1:0] HalfInit   = 16'h8000;
  localparam logic [FracBits-1:0] ZeroInit   = 16'h0000;

  // Channel codes, also the average memory addresses
  typedef enum logic [ChBits-1:0] {
    CH_VOLUME = 3'd0,
    CH_TEMPO  = 3'd1,
    CH_CUTOFF = 3'd2,
    CH_ECHO   = 3'd3,
    CH_WAVE   = 3'd4
  } acs_ch_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_ALPHA_MAIN   = 3'd0,
    REG_ALPHA_FILTER = 3'd1,
    REG_ALPHA_WAVE   = 3'd2,
    REG_BPM_MIN      = 3'd3,
    REG_BPM_MAX      = 3'd4,
    REG_CUTOFF_MIN   = 3'd5,
    REG_CUTOFF_MAX   = 3'd6
  } acs_reg_e;

  // One scan tick
  typedef struct packed {
    logic [11:0]        volume_sample;
    logic               volume_ok;
    logic [11:0]        tempo_sample;
    logic               tempo_ok;
    logic [11:0]        cutoff_sample;
    logic               cutoff_ok;
    logic signed [15:0] echo_sample;
    logic               echo_ok;
    logic signed [15:0] wave_sample;
    logic               wave_ok;
  } acs_item_t;

  // Write beat into the average memory
  typedef struct packed {
    logic                we;
    acs_ch_e             addr;
    logic [FracBits-1:0] data;
  } acs_mem_wr_t;

  // Value an average holds until its first write
  function automatic logic [FracBits-1:0] avg_init(acs_ch_e ch);
    logic [FracBits-1:0] val;
    unique case (ch)
      CH_VOLUME: val = VolumeInit;
      CH_TEMPO:  val = HalfInit;
      CH_CUTOFF: val = HalfInit;
      CH_ECHO:   val = ZeroInit;
      CH_WAVE:   val = ZeroInit;
      default:   val = ZeroInit;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/acs_if.sv -----
// Handshake channels of the analog control smoother: scan tick in, result out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface acs_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        volume_sample;
  logic               volume_ok;
  logic [11:0]        tempo_sample;
  logic               tempo_ok;
  logic [11:0]        cutoff_sample;
  logic               cutoff_ok;
  logic signed [15:0] echo_sample;
  logic               echo_ok;
  logic signed [15:0] wave_sample;
  logic               wave_ok;

  modport source (
    output valid, volume_sample, volume_ok, tempo_sample, tempo_ok,
           cutoff_sample, cutoff_ok, echo_sample, echo_ok, wave_sample, wave_ok,
    input  ready
  );
  modport sink (
    input  valid, volume_sample, volume_ok, tempo_sample, tempo_ok,
           cutoff_sample, cutoff_ok, echo_sample, echo_ok, wave_sample, wave_ok,
    output ready
  );
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] volume_level;
  logic [7:0]  led_tempo;
  logic [14:0] cutoff_hz;
  logic [15:0] wave_mix;
  logic [15:0] echo_mix;

  modport source (
    output valid, volume_level, led_tempo, cutoff_hz, wave_mix, echo_mix,
    input  ready
  );
  modport sink (
    input  valid, volume_level, led_tempo, cutoff_hz, wave_mix, echo_mix,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/acs_avg_mem.sv -----
// Average memory: one 16-bit entry per channel, one read and one write port.
// Read data is registered; an entry never written reads as its reset value.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acs_avg_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  acs_pkg::acs_ch_e               rd_addr_i,
  output logic [acs_pkg::FracBits-1:0]   rd_data_o,
  input  acs_pkg::acs_mem_wr_t           wr_i
);

  logic [acs_pkg::FracBits-1:0] mem [0:acs_pkg::NumCh-1];
  logic [acs_pkg::NumCh-1:0]    written_q;
  logic [acs_pkg::FracBits-1:0] rd_data_q;
  logic                         rd_written_q;
  acs_pkg::acs_ch_e             rd_addr_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Written flags and read-side bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      rd_addr_q    <= acs_pkg::CH_VOLUME;
    end else begin
      if (wr_i.we) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
        rd_addr_q    <= rd_addr_i;
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : acs_pkg::avg_init(rd_addr_q);

endmodule

`default_nettype wire

// ----- rtl/core/acs_ema.sv -----
// Per-channel update: sample normalization and one moving-average step.
// avg' = avg + floor((sample - avg) * alpha / 256), kept when the ok flag is clear.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acs_ema (
  input  acs_pkg::acs_ch_e                ch_i,
  input  acs_pkg::acs_item_t              item_i,
  input  logic [acs_pkg::AlphaBits-1:0]   alpha_main_i,
  input  logic [acs_pkg::AlphaBits-1:0]   alpha_filter_i,
  input  logic [acs_pkg::AlphaBits-1:0]   alpha_wave_i,
  input  logic [acs_pkg::FracBits-1:0]    avg_i,
  output logic [acs_pkg::FracBits-1:0]    avg_o
);

  // 12-bit reading spread over 16 bits by bit replication
  function automatic logic [15:0] norm_local(logic [11:0] x);
    return {x, x[11:8]};
  endfunction

  // Signed reading: negatives to zero, 15 magnitude bits replicated
  function automatic logic [15:0] norm_signed(logic signed [15:0] x);
    logic [15:0] val;
    if (x[15]) begin
      val = 16'h0000;
    end else begin
      val = {x[14:0], x[14]};
    end
    return val;
  endfunction

  logic [15:0]        sample;
  logic               ok;
  logic [8:0]         alpha_raw;
  logic [8:0]         alpha;
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [26:0] step;
  logic signed [26:0] sum;

  // Channel select
  always_comb begin
    unique case (ch_i)
      acs_pkg::CH_VOLUME: begin
        sample    = norm_local(item_i.volume_sample);
        ok        = item_i.volume_ok;
        alpha_raw = alpha_main_i;
      end
      acs_pkg::CH_TEMPO: begin
        sample    = norm_local(item_i.tempo_sample);
        ok        = item_i.tempo_ok;
        alpha_raw = alpha_main_i;
      end
      acs_pkg::CH_CUTOFF: begin
        sample    = norm_local(item_i.cutoff_sample);
        ok        = item_i.cutoff_ok;
        alpha_raw = alpha_filter_i;
      end
      acs_pkg::CH_ECHO: begin
        sample    = norm_signed(item_i.echo_sample);
        ok        = item_i.echo_ok;
        alpha_raw = alpha_main_i;
      end
      acs_pkg::CH_WAVE: begin
        sample    = norm_signed(item_i.wave_sample);
        ok        = item_i.wave_ok;
        alpha_raw = alpha_wave_i;
      end
      default: begin
        sample    = 16'h0000;
        ok        = 1'b0;
        alpha_raw = 9'd0;
      end
    endcase
  end

  // Weight saturates at one
  assign alpha = (alpha_raw > 9'(acs_pkg::AlphaOne)) ? 9'(acs_pkg::AlphaOne) : alpha_raw;

  // Signed step, arithmetic shift gives the floor
  assign diff  = $signed({1'b0, sample}) - $signed({1'b0, avg_i});
  assign prod  = diff * $signed({1'b0, alpha});
  assign step  = prod >>> 8;
  assign sum   = $signed({11'b0, avg_i}) + step;
  assign avg_o = ok ? sum[15:0] : avg_i;

endmodule

`default_nettype wire

// ----- rtl/core/acs_out_map.sv -----
// Output mapping: rounded LED tempo, truncated cutoff in Hz, snapped wave mix.
// Products are registered on load; the divide by full scale follows from them.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module acs_out_map (
  input  logic        clk_i,
  input  logic        ld_i,
  input  logic [7:0]  bpm_min_i,
  input  logic [7:0]  bpm_max_i,
  input  logic [14:0] cutoff_min_i,
  input  logic [14:0] cutoff_max_i,
  input  logic [15:0] tempo_avg_i,
  input  logic [15:0] cutoff_avg_i,
  input  logic [15:0] wave_avg_i,
  output logic [7:0]  led_tempo_o,
  output logic [14:0] cutoff_hz_o,
  output logic [15:0] wave_mix_o
);

  // Snap points: above 0.98 full goes to full, below 0.02 full goes to zero
  localparam logic [15:0] WaveHi  = 16'((98 * 65535) / 100);
  localparam logic [15:0] WaveLo  = 16'((2 * 65535 + 99) / 100);
  localparam logic [16:0] FullDiv = 17'h0FFFF;

  // floor(x / 65535) for x below 65535 * 32770: one estimate, one correction
  function automatic logic [16:0] div_full(logic [31:0] x);
    logic [15:0] q0;
    logic [16:0] r0;
    q0 = x[31:16];
    r0 = {1'b0, x[15:0]} + {1'b0, q0};
    return {1'b0, q0} + ((r0 >= FullDiv) ? 17'd1 : 17'd0);
  endfunction

  logic        led_inv;
  logic [7:0]  led_span;
  logic [24:0] led_x_d;
  logic        hz_inv;
  logic [14:0] hz_span;
  logic [31:0] hz_x_d;
  logic [15:0] wave_d;

  logic        led_inv_q;
  logic [7:0]  bpm_min_q;
  logic [7:0]  bpm_max_q;
  logic [24:0] led_x_q;
  logic        hz_inv_q;
  logic [14:0] hz_min_q;
  logic [31:0] hz_x_q;
  logic [15:0] wave_q;
  logic [16:0] led_div;
  logic [16:0] hz_div;

  // Spans and products; the half-unit bias rounds the tempo, the near-unit
  // bias turns the downward cutoff map into a ceiling
  always_comb begin
    led_inv  = bpm_max_i < bpm_min_i;
    led_span = led_inv ? 8'd0 : (bpm_max_i - bpm_min_i);
    led_x_d  = 25'(tempo_avg_i) * 25'(led_span) + 25'd32767;
    hz_inv   = cutoff_max_i < cutoff_min_i;
    hz_span  = hz_inv ? (cutoff_min_i - cutoff_max_i) : (cutoff_max_i - cutoff_min_i);
    hz_x_d   = 32'(cutoff_avg_i) * 32'(hz_span) + (hz_inv ? 32'd65534 : 32'd0);
    if (wave_avg_i > WaveHi) begin
      wave_d = 16'hFFFF;
    end else if (wave_avg_i < WaveLo) begin
      wave_d = 16'h0000;
    end else begin
      wave_d = wave_avg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      led_inv_q <= led_inv;
      bpm_min_q <= bpm_min_i;
      bpm_max_q <= bpm_max_i;
      led_x_q   <= led_x_d;
      hz_inv_q  <= hz_inv;
      hz_min_q  <= cutoff_min_i;
      hz_x_q    <= hz_x_d;
      wave_q    <= wave_d;
    end
  end

  // Quotients never exceed the span, so no clamp is needed
  assign led_div     = div_full({7'b0, led_x_q});
  assign hz_div      = div_full(hz_x_q);
  assign led_tempo_o = led_inv_q ? bpm_max_q : (bpm_min_q + led_div[7:0]);
  assign cutoff_hz_o = hz_inv_q ? (hz_min_q - hz_div[14:0]) : (hz_min_q + hz_div[14:0]);
  assign wave_mix_o  = wave_q;

endmodule

`default_nettype wire

// ----- rtl/core/analog_control_smoother.sv -----
// Top level of the analog control smoother: sequencer, registers, result stage.
// Depends on acs_pkg, acs_if, acs_avg_mem, acs_ema, acs_out_map.
//
// One scan tick in, one result out. The five channel averages live in a
// five-entry memory with one read and one write port; a tick reads one channel
// per cycle and writes its update back the cycle after, so an item holds the
// block from acceptance to the next acceptance through five reads, the last
// write-back, the output products, the divide and result load, and the idle
// state that takes the next tick. Read and write-back in the same cycle always
// touch different channels. The result sits in an output register, so the next
// tick is taken while a result still waits; a new result is loaded only once
// the old one has gone, and the result stage holds until then. Configuration
// is to be written by the user through cfg_we_i, cfg_idx_i and cfg_wdata_i
// only while the block is idle; the block does not enforce it. Indexes beyond
// the register list are ignored. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module analog_control_smoother (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [acs_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [acs_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  acs_in_if.sink                              smp_i,
  acs_out_if.source                           res_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MAP   = 5'b01000,
    ST_FIN   = 5'b10000
  } acs_state_e;

  // Configuration registers
  logic [8:0]  alpha_main_q, alpha_filter_q, alpha_wave_q;
  logic [7:0]  bpm_min_q, bpm_max_q;
  logic [14:0] cutoff_min_q, cutoff_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_main_q   <= 9'd64;
      alpha_filter_q <= 9'd115;
      alpha_wave_q   <= 9'd90;
      bpm_min_q      <= 8'd40;
      bpm_max_q      <= 8'd240;
      cutoff_min_q   <= 15'd300;
      cutoff_max_q   <= 15'd6000;
    end else if (cfg_we_i) begin
      unique case (acs_pkg::acs_reg_e'(cfg_idx_i))
        acs_pkg::REG_ALPHA_MAIN:   alpha_main_q   <= cfg_wdata_i[8:0];
        acs_pkg::REG_ALPHA_FILTER: alpha_filter_q <= cfg_wdata_i[8:0];
        acs_pkg::REG_ALPHA_WAVE:   alpha_wave_q   <= cfg_wdata_i[8:0];
        acs_pkg::REG_BPM_MIN:      bpm_min_q      <= cfg_wdata_i[7:0];
        acs_pkg::REG_BPM_MAX:      bpm_max_q      <= cfg_wdata_i[7:0];
        acs_pkg::REG_CUTOFF_MIN:   cutoff_min_q   <= cfg_wdata_i;
        acs_pkg::REG_CUTOFF_MAX:   cutoff_max_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  acs_state_e         state_q, state_d;
  acs_pkg::acs_ch_e   ch_q;
  acs_pkg::acs_ch_e   rd_ch_q;
  logic               rd_vld_q;
  acs_pkg::acs_item_t item_q;
  logic               in_beat;
  logic               fin_go;
  logic               out_valid_q;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign in_beat     = smp_i.valid && smp_i.ready;
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_beat) state_d = ST_READ;
      ST_READ:  if (ch_q == acs_pkg::CH_WAVE) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_MAP;
      ST_MAP:   state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ch_q     <= acs_pkg::CH_VOLUME;
      rd_ch_q  <= acs_pkg::CH_VOLUME;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_READ);
      rd_ch_q  <= ch_q;
      if (in_beat) begin
        ch_q <= acs_pkg::CH_VOLUME;
      end else if (state_q == ST_READ && ch_q != acs_pkg::CH_WAVE) begin
        ch_q <= acs_pkg::acs_ch_e'(ch_q + 3'd1);
      end
    end
  end

  // Latch the tick
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q.volume_sample <= smp_i.volume_sample;
      item_q.volume_ok     <= smp_i.volume_ok;
      item_q.tempo_sample  <= smp_i.tempo_sample;
      item_q.tempo_ok      <= smp_i.tempo_ok;
      item_q.cutoff_sample <= smp_i.cutoff_sample;
      item_q.cutoff_ok     <= smp_i.cutoff_ok;
      item_q.echo_sample   <= smp_i.echo_sample;
      item_q.echo_ok       <= smp_i.echo_ok;
      item_q.wave_sample   <= smp_i.wave_sample;
      item_q.wave_ok       <= smp_i.wave_ok;
    end
  end

  // Average memory: read channel ch_q, write back rd_ch_q in the cycle after
  logic [15:0]          rd_data;
  logic [15:0]          avg_new;
  acs_pkg::acs_mem_wr_t mem_wr;

  assign mem_wr.we   = rd_vld_q;
  assign mem_wr.addr = rd_ch_q;
  assign mem_wr.data = avg_new;

  acs_avg_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (ch_q),
    .rd_data_o (rd_data),
    .wr_i      (mem_wr)
  );

  acs_ema u_ema (
    .ch_i           (rd_ch_q),
    .item_i         (item_q),
    .alpha_main_i   (alpha_main_q),
    .alpha_filter_i (alpha_filter_q),
    .alpha_wave_i   (alpha_wave_q),
    .avg_i          (rd_data),
    .avg_o          (avg_new)
  );

  // Updated averages of the current tick
  logic [15:0] vol_avg_q, tempo_avg_q, cutoff_avg_q, echo_avg_q, wave_avg_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      unique case (rd_ch_q)
        acs_pkg::CH_VOLUME: vol_avg_q    <= avg_new;
        acs_pkg::CH_TEMPO:  tempo_avg_q  <= avg_new;
        acs_pkg::CH_CUTOFF: cutoff_avg_q <= avg_new;
        acs_pkg::CH_ECHO:   echo_avg_q   <= avg_new;
        acs_pkg::CH_WAVE:   wave_avg_q   <= avg_new;
        default: ;
      endcase
    end
  end

  // Output mapping
  logic [7:0]  led_tempo;
  logic [14:0] cutoff_hz;
  logic [15:0] wave_mix;

  acs_out_map u_map (
    .clk_i        (clk_i),
    .ld_i         (state_q == ST_MAP),
    .bpm_min_i    (bpm_min_q),
    .bpm_max_i    (bpm_max_q),
    .cutoff_min_i (cutoff_min_q),
    .cutoff_max_i (cutoff_max_q),
    .tempo_avg_i  (tempo_avg_q),
    .cutoff_avg_i (cutoff_avg_q),
    .wave_avg_i   (wave_avg_q),
    .led_tempo_o  (led_tempo),
    .cutoff_hz_o  (cutoff_hz),
    .wave_mix_o   (wave_mix)
  );

  // Result register
  logic [15:0] res_volume_q, res_wave_q, res_echo_q;
  logic [7:0]  res_led_q;
  logic [14:0] res_hz_q;

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      res_volume_q <= vol_avg_q;
      res_led_q    <= led_tempo;
      res_hz_q     <= cutoff_hz;
      res_wave_q   <= wave_mix;
      res_echo_q   <= echo_avg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.volume_level = res_volume_q;
  assign res_o.led_tempo    = res_led_q;
  assign res_o.cutoff_hz    = res_hz_q;
  assign res_o.wave_mix     = res_wave_q;
  assign res_o.echo_mix     = res_echo_q;

  // Checks
  a_start_volume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_READ && ch_q == acs_pkg::CH_VOLUME))
    else $error("tick did not start at the volume channel");

  a_all_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && $past(state_q) == ST_MAP) |->
      ($past(state_q, 3) == ST_READ && $past(ch_q, 3) == acs_pkg::CH_WAVE))
    else $error("result stage reached before the last channel was read");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && state_q == ST_READ) |-> (rd_ch_q != ch_q))
    else $error("read and write-back hit the same channel");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the result stage");

endmodule

`default_nettype wire

// ----- tb/analog_control_smoother_tb.sv -----
// Testbench of the analog control smoother: random and directed scan ticks, checked
// beat by beat against a cycle-free predictor of the five channel averages.
// Depends on acs_pkg, acs_if and the analog_control_smoother RTL.
`timescale 1ns / 1ps

module analog_control_smoother_tb;
  import acs_pkg::*;

  localparam int unsigned FullScale   = (1 << FracBits) - 1;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned PhaseTicks  = 216;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned LocalMax    = 4095;
  localparam int unsigned SignedMax   = 32767;
  // Only index left unused by the register list
  localparam logic [CfgIdxBits-1:0] RegBeyondList = 3'd7;

  // One result beat
  typedef struct packed {
    logic [15:0] volume_level;
    logic [7:0]  led_tempo;
    logic [14:0] cutoff_hz;
    logic [15:0] wave_mix;
    logic [15:0] echo_mix;
  } readout_t;

  // Tracks registers and averages, queues the readout each tick should produce
  class smoothing_tracker;
    logic [8:0]          alpha_main, alpha_filter, alpha_wave;
    logic [7:0]          bpm_min, bpm_max;
    logic [14:0]         cutoff_min, cutoff_max;
    logic [FracBits-1:0] avg [NumCh];
    readout_t            expected_readouts [$];
    int unsigned         mismatches;

    function new();
      alpha_main       = 9'd64;
      alpha_filter     = 9'd115;
      alpha_wave       = 9'd90;
      bpm_min          = 8'd40;
      bpm_max          = 8'd240;
      cutoff_min       = 15'd300;
      cutoff_max       = 15'd6000;
      avg[CH_VOLUME]   = VolumeInit;
      avg[CH_TEMPO]    = HalfInit;
      avg[CH_CUTOFF]   = HalfInit;
      avg[CH_ECHO]     = ZeroInit;
      avg[CH_WAVE]     = ZeroInit;
      mismatches       = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        REG_ALPHA_MAIN:   alpha_main   = val[8:0];
        REG_ALPHA_FILTER: alpha_filter = val[8:0];
        REG_ALPHA_WAVE:   alpha_wave   = val[8:0];
        REG_BPM_MIN:      bpm_min      = val[7:0];
        REG_BPM_MAX:      bpm_max      = val[7:0];
        REG_CUTOFF_MIN:   cutoff_min   = val[14:0];
        REG_CUTOFF_MAX:   cutoff_max   = val[14:0];
        default: ;
      endcase
    endfunction

    // 12-bit reading replicated up to 16 bits
    static function logic [15:0] local_frac(logic [11:0] raw);
      return {raw, raw[11:8]};
    endfunction

    // Negative readings count as zero, 15 magnitude bits replicated
    static function logic [15:0] signed_frac(logic [15:0] raw);
      return raw[15] ? 16'd0 : {raw[14:0], raw[14]};
    endfunction

    // avg' = floor((avg*(256-a) + s*a) / 256), alpha saturating at one
    static function logic [15:0] ema_step(logic [15:0] cur, logic [15:0] smp,
                                          logic [8:0] alpha);
      int unsigned w;
      int unsigned sum;
      w   = (alpha > AlphaOne) ? AlphaOne : alpha;
      sum = int'(cur) * (AlphaOne - w) + int'(smp) * w;
      return 16'(sum >> 8);
    endfunction

    function void note_tick(acs_item_t it);
      readout_t        r;
      longint unsigned span;
      longint unsigned lvl;
      longint unsigned w;
      if (it.volume_ok)
        avg[CH_VOLUME] = ema_step(avg[CH_VOLUME], local_frac(it.volume_sample), alpha_main);
      if (it.tempo_ok)
        avg[CH_TEMPO] = ema_step(avg[CH_TEMPO], local_frac(it.tempo_sample), alpha_main);
      if (it.cutoff_ok)
        avg[CH_CUTOFF] = ema_step(avg[CH_CUTOFF], local_frac(it.cutoff_sample), alpha_filter);
      if (it.echo_ok)
        avg[CH_ECHO] = ema_step(avg[CH_ECHO], signed_frac(it.echo_sample), alpha_main);
      if (it.wave_ok)
        avg[CH_WAVE] = ema_step(avg[CH_WAVE], signed_frac(it.wave_sample), alpha_wave);

      // LED tempo: rounded half up, clamped; inverted bounds pin it to bpm_max
      if (bpm_max < bpm_min) begin
        r.led_tempo = bpm_max;
      end else begin
        span = bpm_max - bpm_min;
        lvl  = bpm_min + (2 * longint'(avg[CH_TEMPO]) * span + FullScale) / (2 * FullScale);
        if (lvl < bpm_min) lvl = bpm_min;
        if (lvl > bpm_max) lvl = bpm_max;
        r.led_tempo = 8'(lvl);
      end

      // Cutoff: floor going up, ceiling taken off when the bounds are inverted
      if (cutoff_max >= cutoff_min) begin
        span = cutoff_max - cutoff_min;
        lvl  = cutoff_min + (longint'(avg[CH_CUTOFF]) * span) / FullScale;
      end else begin
        span = cutoff_min - cutoff_max;
        lvl  = cutoff_min - (longint'(avg[CH_CUTOFF]) * span + FullScale - 1) / FullScale;
      end
      r.cutoff_hz = 15'(lvl);

      // Wave mix snaps to the ends outside 2% .. 98%
      w = avg[CH_WAVE];
      if (w * 100 > 98 * FullScale) w = FullScale;
      else if (w * 100 < 2 * FullScale) w = 0;
      r.wave_mix = 16'(w);

      r.volume_level = avg[CH_VOLUME];
      r.echo_mix     = avg[CH_ECHO];
      expected_readouts.push_back(r);
    endfunction

    function void check_result(readout_t got);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("mismatch at %0t: result beat with no tick outstanding", $time);
        return;
      end
      want = expected_readouts.pop_front();
      if (got.volume_level !== want.volume_level || got.led_tempo !== want.led_tempo ||
          got.cutoff_hz !== want.cutoff_hz || got.wave_mix !== want.wave_mix ||
          got.echo_mix !== want.echo_mix) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("mismatch at %0t (exp/got): volume %0d/%0d led %0d/%0d cutoff %0d/%0d",
                   $time, want.volume_level, got.volume_level, want.led_tempo,
                   got.led_tempo, want.cutoff_hz, got.cutoff_hz);
          $display("  wave %0d/%0d echo %0d/%0d",
                   want.wave_mix, got.wave_mix, want.echo_mix, got.echo_mix);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_readouts.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  acs_in_if  smp_if ();
  acs_out_if res_if ();

  smoothing_tracker tracker;
  int unsigned      cycles;
  int unsigned      src_quiet_left;
  int unsigned      sink_quiet_left;
  int unsigned      sink_stall_left;
  int unsigned      lvl_local [3];
  int unsigned      lvl_signed [2];

  analog_control_smoother dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp_if),
    .res_o       (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned src_gap();
    int unsigned roll;
    if (src_quiet_left > 0) begin
      src_quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      src_quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    return gap_len();
  endfunction

  // Level a channel hovers around: near either end or anywhere
  function automatic int unsigned new_level(int unsigned top);
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, top / 50);
      1:       return top - $urandom_range(0, top / 50);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic logic [11:0] pick_local(int unsigned level);
    int v;
    case ($urandom_range(0, 19))
      0:       return 12'($urandom_range(0, LocalMax));
      1:       return 12'd0;
      2:       return 12'(LocalMax);
      default: begin
        v = int'(level) + int'($urandom_range(0, 64)) - 32;
        if (v < 0) v = 0;
        if (v > int'(LocalMax)) v = LocalMax;
        return 12'(v);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_signed(int unsigned level);
    int v;
    case ($urandom_range(0, 19))
      0:       return 16'($urandom);
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3:       return {1'b1, 15'($urandom)};
      default: begin
        v = int'(level) + int'($urandom_range(0, 512)) - 256;
        if (v < 0) v = 0;
        if (v > int'(SignedMax)) v = SignedMax;
        return 16'(v);
      end
    endcase
  endfunction

  function automatic acs_item_t make_tick(logic [11:0] vol, logic vok, logic [11:0] tmp,
                                          logic tok, logic [11:0] cut, logic cok,
                                          logic [15:0] echo, logic eok,
                                          logic [15:0] wave, logic wok);
    acs_item_t it;
    it.volume_sample = vol;
    it.volume_ok     = vok;
    it.tempo_sample  = tmp;
    it.tempo_ok      = tok;
    it.cutoff_sample = cut;
    it.cutoff_ok     = cok;
    it.echo_sample   = echo;
    it.echo_ok       = eok;
    it.wave_sample   = wave;
    it.wave_ok       = wok;
    return it;
  endfunction

  // Tick around drifting levels, with full-range outliers and dropped flags
  function automatic acs_item_t random_tick();
    logic [4:0] oks;
    for (int i = 0; i < 3; i++)
      if ($urandom_range(0, 29) == 0) lvl_local[i] = new_level(LocalMax);
    for (int i = 0; i < 2; i++)
      if ($urandom_range(0, 29) == 0) lvl_signed[i] = new_level(SignedMax);
    for (int i = 0; i < 5; i++)
      oks[i] = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 39) == 0) oks = '0;
    return make_tick(pick_local(lvl_local[0]), oks[0], pick_local(lvl_local[1]), oks[1],
                     pick_local(lvl_local[2]), oks[2], pick_signed(lvl_signed[0]), oks[3],
                     pick_signed(lvl_signed[1]), oks[4]);
  endfunction

  // Present one tick, hold it until the beat is taken; returns at a falling edge
  task automatic send_tick(acs_item_t it);
    int unsigned gap;
    gap = src_gap();
    if (gap > 0) begin
      smp_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.volume_sample = it.volume_sample;
    smp_if.volume_ok     = it.volume_ok;
    smp_if.tempo_sample  = it.tempo_sample;
    smp_if.tempo_ok      = it.tempo_ok;
    smp_if.cutoff_sample = it.cutoff_sample;
    smp_if.cutoff_ok     = it.cutoff_ok;
    smp_if.echo_sample   = it.echo_sample;
    smp_if.echo_ok       = it.echo_ok;
    smp_if.wave_sample   = it.wave_sample;
    smp_if.wave_ok       = it.wave_ok;
    smp_if.valid         = 1'b1;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
    tracker.note_tick(it);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = CfgDataBits'(val);
    @(posedge clk_i);
    tracker.set_reg(idx, CfgDataBits'(val));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    smp_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register settings per phase: saturation, frozen, inverted, unit, random, reset
  task automatic apply_phase(int unsigned ph);
    int unsigned am, af, aw, bl, bh, cl, ch;
    case (ph)
      0: begin am = 256; af = 256; aw = 256; bl = 1;   bh = 255; cl = 0;     ch = 24000; end
      1: begin am = 0;   af = 0;   aw = 0;   bl = 255; bh = 255; cl = 24000; ch = 24000; end
      2: begin am = 511; af = 300; aw = 257; bl = 200; bh = 100; cl = 6000;  ch = 300;   end
      3: begin am = 1;   af = 1;   aw = 1;   bl = 1;   bh = 1;   cl = 0;     ch = 0;     end
      7: begin am = 64;  af = 115; aw = 90;  bl = 40;  bh = 240; cl = 300;   ch = 6000;  end
      default: begin
        am = $urandom_range(0, 511);
        af = $urandom_range(0, 511);
        aw = $urandom_range(0, 511);
        bl = $urandom_range(0, 255);
        bh = $urandom_range(0, 255);
        cl = $urandom_range(0, 32767);
        ch = $urandom_range(0, 32767);
      end
    endcase
    write_reg(REG_ALPHA_MAIN, am);
    write_reg(REG_ALPHA_FILTER, af);
    write_reg(REG_ALPHA_WAVE, aw);
    write_reg(REG_BPM_MIN, bl);
    write_reg(REG_BPM_MAX, bh);
    write_reg(REG_CUTOFF_MIN, cl);
    write_reg(REG_CUTOFF_MAX, ch);
    write_reg(RegBeyondList, $urandom_range(0, 32767));
    cfg_we_i = 1'b0;
  endtask

  // Result side: random back-pressure with quiet stretches
  always @(negedge clk_i) begin
    int unsigned roll;
    if (!rst_ni) begin
      res_if.ready = 1'b0;
    end else if (sink_quiet_left > 0) begin
      sink_quiet_left--;
      res_if.ready = 1'b1;
    end else if (sink_stall_left > 0) begin
      sink_stall_left--;
      res_if.ready = 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        sink_quiet_left = $urandom_range(20, 60);
        res_if.ready = 1'b1;
      end else if (roll < 60) begin
        res_if.ready = 1'b1;
      end else begin
        sink_stall_left = gap_len() - 1;
        res_if.ready = 1'b0;
      end
    end
  end

  // Result check and run limit
  always @(posedge clk_i) begin
    readout_t beat;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL analog_control_smoother");
      $finish;
    end else if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      beat.volume_level = res_if.volume_level;
      beat.led_tempo    = res_if.led_tempo;
      beat.cutoff_hz    = res_if.cutoff_hz;
      beat.wave_mix     = res_if.wave_mix;
      beat.echo_mix     = res_if.echo_mix;
      tracker.check_result(beat);
    end
  end

  initial begin
    tracker              = new();
    cycles               = 0;
    src_quiet_left       = 0;
    sink_quiet_left      = 0;
    sink_stall_left      = 0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_ALPHA_MAIN;
    cfg_wdata_i          = '0;
    smp_if.valid         = 1'b0;
    smp_if.volume_sample = '0;
    smp_if.volume_ok     = 1'b0;
    smp_if.tempo_sample  = '0;
    smp_if.tempo_ok      = 1'b0;
    smp_if.cutoff_sample = '0;
    smp_if.cutoff_ok     = 1'b0;
    smp_if.echo_sample   = '0;
    smp_if.echo_ok       = 1'b0;
    smp_if.wave_sample   = '0;
    smp_if.wave_ok       = 1'b0;
    res_if.ready         = 1'b0;
    foreach (lvl_local[i]) lvl_local[i] = new_level(LocalMax);
    foreach (lvl_signed[i]) lvl_signed[i] = new_level(SignedMax);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed ticks at reset settings: ends of scale, negatives, flags, bit patterns
    send_tick(make_tick(12'hfff, 1, 12'hfff, 1, 12'hfff, 1, 16'h7fff, 1, 16'h7fff, 1));
    send_tick(make_tick(12'h000, 1, 12'h000, 1, 12'h000, 1, 16'h0000, 1, 16'h0000, 1));
    send_tick(make_tick(12'hfff, 1, 12'hfff, 1, 12'hfff, 1, 16'h8000, 1, 16'hffff, 1));
    send_tick(make_tick(12'hfff, 0, 12'hfff, 0, 12'h000, 0, 16'h7fff, 0, 16'h7fff, 0));
    send_tick(make_tick(12'haaa, 1, 12'h555, 1, 12'haaa, 1, 16'haaaa, 1, 16'h5555, 1));
    send_tick(make_tick(12'h555, 1, 12'haaa, 1, 12'h555, 1, 16'h5555, 1, 16'haaaa, 1));
    send_tick(make_tick(12'hfff, 1, 12'hfff, 0, 12'hfff, 1, 16'h7fff, 0, 16'h7fff, 1));
    send_tick(make_tick(12'h000, 0, 12'h000, 1, 12'h000, 0, 16'h7fff, 1, 16'h0000, 0));
    // Full scale long enough for the wave mix to snap high
    repeat (10)
      send_tick(make_tick(12'hfff, 1, 12'hfff, 1, 12'hfff, 1, 16'h7fff, 1, 16'h7fff, 1));
    // Only the wave channel falls back toward zero
    repeat (7)
      send_tick(make_tick(12'h000, 0, 12'h000, 0, 12'h000, 0, 16'h0000, 0, 16'h0000, 1));
    wait_idle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      apply_phase(ph);
      repeat (PhaseTicks) send_tick(random_tick());
      wait_idle();
    end

    repeat (12) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS analog_control_smoother");
    end else begin
      $display("FAIL analog_control_smoother");
    end
    $finish;
  end

endmodule
